FILE: rtl/psca_pkg.sv
// ----------------------------------------------------------------------------
// psca_pkg
// shared types, constants and helpers of the saturation / contrast adjust unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psca_pkg;

	localparam int PIX_W    = 8;
	localparam int GAIN_W   = 10;
	localparam int HUE_FRAC = 12;
	localparam int HUE_W    = 15;             // 0 .. 6*4096-1
	localparam int Q_W      = HUE_FRAC + 1;   // quotient magnitude 0 .. 4096
	localparam int C8_W     = 16;             // chroma, 8 fractional bits
	localparam int CFG_IDX_W = 2;

	localparam logic [PIX_W-1:0]  MID_LEVEL = 8'd128;
	localparam logic [PIX_W-1:0]  TOP_LEVEL = 8'd255;
	localparam logic [GAIN_W-1:0] GAIN_ONE  = 10'd256;

	// floor(s/3) for s <= 765 as (s*683) >> 11
	localparam logic [9:0] RECIP3    = 10'd683;
	localparam int         RECIP3_SH = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRAYSCALE  = 2'd0,
		CFG_CONTRAST   = 2'd1,
		CFG_SATURATION = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic              grayscale_enable;
		logic [GAIN_W-1:0] contrast_gain;
		logic [GAIN_W-1:0] saturation_gain;
	} cfg_t;

	// one restoring division step: {quotient bit, new remainder}
	function automatic logic [PIX_W:0] div_step(input logic [PIX_W-1:0] rem,
		input logic [PIX_W-1:0] den);
		logic [PIX_W:0] t;
		logic [PIX_W:0] d;
		t = {rem, 1'b0};
		d = {1'b0, den};
		if (t >= d) begin
			t = t - d;
			return {1'b1, t[PIX_W-1:0]};
		end
		return {1'b0, t[PIX_W-1:0]};
	endfunction

endpackage

`default_nettype wire

FILE: rtl/psca_hue.sv
// ----------------------------------------------------------------------------
// psca_hue
// max/min, pipelined hue division and chroma, five register stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psca_hue (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [psca_pkg::PIX_W-1:0]    red,
	input  wire logic [psca_pkg::PIX_W-1:0]    green,
	input  wire logic [psca_pkg::PIX_W-1:0]    blue,
	input  wire logic [psca_pkg::GAIN_W-1:0]   saturation_gain,
	output logic                               hue_valid,
	input  wire logic                          hue_ready,
	output logic [psca_pkg::HUE_W-1:0]         hue,
	output logic [psca_pkg::C8_W-1:0]          chroma,
	output logic [psca_pkg::PIX_W-1:0]         max_val
);

	typedef enum logic [1:0] {SEL_RED, SEL_GREEN, SEL_BLUE} sel_t;

	localparam int PW = psca_pkg::PIX_W;
	localparam int QW = psca_pkg::Q_W;
	localparam int RAW_W = PW + psca_pkg::GAIN_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	assign en5 = !v_s5 || hue_ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// stage 1: max, min and signed numerator
	logic [PW-1:0] mx, mn, nabs;
	logic          neg;
	sel_t          sel;
	logic [PW:0]   num;

	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		if (blue == mx) begin
			sel = SEL_BLUE;
			num = {1'b0, red} - {1'b0, green};
		end else if (green == mx) begin
			sel = SEL_GREEN;
			num = {1'b0, blue} - {1'b0, red};
		end else begin
			sel = SEL_RED;
			num = {1'b0, green} - {1'b0, blue};
		end
		neg = num[PW];
		nabs = neg ? PW'(-num) : num[PW-1:0];
	end

	logic [PW-1:0] mx_s1, delta_s1, nabs_s1;
	logic          neg_s1;
	sel_t          sel_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			mx_s1    <= mx;
			delta_s1 <= mx - mn;
			nabs_s1  <= nabs;
			neg_s1   <= neg;
			sel_s1   <= sel;
		end
	end

	// stage 2: top quotient bit plus three steps, raw chroma product
	logic [PW-1:0] rem2;
	logic [3:0]    qb2;
	logic [PW:0]   st2;

	always_comb begin
		qb2[3] = (nabs_s1 >= delta_s1);
		rem2 = qb2[3] ? nabs_s1 - delta_s1 : nabs_s1;
		for (int i = 2; i >= 0; i--) begin
			st2 = psca_pkg::div_step(rem2, delta_s1);
			qb2[i] = st2[PW];
			rem2 = st2[PW-1:0];
		end
	end

	logic [PW-1:0]    mx_s2, delta_s2, rem_s2;
	logic [QW-1:0]    q_s2;
	logic             neg_s2;
	sel_t             sel_s2;
	logic [RAW_W-1:0] raw_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			mx_s2    <= mx_s1;
			delta_s2 <= delta_s1;
			rem_s2   <= rem2;
			q_s2     <= {qb2, 9'd0};
			neg_s2   <= neg_s1;
			sel_s2   <= sel_s1;
			raw_s2   <= RAW_W'(delta_s1) * RAW_W'(saturation_gain);
		end
	end

	// stage 3: quotient bits 8..5, chroma clamp to mx*256
	logic [PW-1:0]     rem3;
	logic [3:0]        qb3;
	logic [PW:0]       st3;
	logic [RAW_W-1:0]  lim3;

	always_comb begin
		rem3 = rem_s2;
		for (int i = 3; i >= 0; i--) begin
			st3 = psca_pkg::div_step(rem3, delta_s2);
			qb3[i] = st3[PW];
			rem3 = st3[PW-1:0];
		end
		lim3 = {2'b00, mx_s2, 8'd0};
	end

	logic [PW-1:0]              mx_s3, delta_s3, rem_s3;
	logic [QW-1:0]              q_s3;
	logic                       neg_s3;
	sel_t                       sel_s3;
	logic [psca_pkg::C8_W-1:0]  c8_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			mx_s3    <= mx_s2;
			delta_s3 <= delta_s2;
			rem_s3   <= rem3;
			q_s3     <= {q_s2[12:9], qb3, 5'd0};
			neg_s3   <= neg_s2;
			sel_s3   <= sel_s2;
			c8_s3    <= (raw_s2 > lim3) ? lim3[psca_pkg::C8_W-1:0]
				: raw_s2[psca_pkg::C8_W-1:0];
		end
	end

	// stage 4: quotient bits 4..1
	logic [PW-1:0] rem4;
	logic [3:0]    qb4;
	logic [PW:0]   st4;

	always_comb begin
		rem4 = rem_s3;
		for (int i = 3; i >= 0; i--) begin
			st4 = psca_pkg::div_step(rem4, delta_s3);
			qb4[i] = st4[PW];
			rem4 = st4[PW-1:0];
		end
	end

	logic [PW-1:0]              mx_s4, delta_s4, rem_s4;
	logic [QW-1:0]              q_s4;
	logic                       neg_s4;
	sel_t                       sel_s4;
	logic [psca_pkg::C8_W-1:0]  c8_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			mx_s4    <= mx_s3;
			delta_s4 <= delta_s3;
			rem_s4   <= rem4;
			q_s4     <= {q_s3[12:5], qb4, 1'b0};
			neg_s4   <= neg_s3;
			sel_s4   <= sel_s3;
			c8_s4    <= c8_s3;
		end
	end

	// stage 5: last quotient bit, sign and sector offset
	logic [PW:0]          st5;
	logic [QW-1:0]        q5;
	logic signed [15:0]   sq5, h5;

	always_comb begin
		st5 = psca_pkg::div_step(rem_s4, delta_s4);
		q5 = {q_s4[12:1], st5[PW]};
		sq5 = neg_s4 ? -$signed({3'b000, q5}) : $signed({3'b000, q5});
		case (sel_s4)
			SEL_BLUE:  h5 = sq5 + 16'sd16384;
			SEL_GREEN: h5 = sq5 + 16'sd8192;
			default:   h5 = sq5[15] ? sq5 + 16'sd24576 : sq5;
		endcase
		// gray pixel takes hue zero
		if (delta_s4 == '0) h5 = '0;
	end

	logic [psca_pkg::HUE_W-1:0] hue_s5;
	logic [psca_pkg::C8_W-1:0]  c8_s5;
	logic [PW-1:0]              mx_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			hue_s5 <= h5[psca_pkg::HUE_W-1:0];
			c8_s5  <= c8_s4;
			mx_s5  <= mx_s4;
		end
	end

	assign hue_valid = v_s5;
	assign hue       = hue_s5;
	assign chroma    = c8_s5;
	assign max_val   = mx_s5;

endmodule

`default_nettype wire

FILE: rtl/psca_rgb.sv
// ----------------------------------------------------------------------------
// psca_rgb
// hue/chroma back to rgb and optional gray mean, four register stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psca_rgb (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [psca_pkg::HUE_W-1:0]   hue,
	input  wire logic [psca_pkg::C8_W-1:0]    chroma,
	input  wire logic [psca_pkg::PIX_W-1:0]   max_val,
	input  wire logic                         grayscale_enable,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [psca_pkg::PIX_W-1:0]        red,
	output logic [psca_pkg::PIX_W-1:0]        green,
	output logic [psca_pkg::PIX_W-1:0]        blue
);

	typedef enum logic [2:0] {
		SECT_R_Y, SECT_Y_G, SECT_G_C, SECT_C_B, SECT_B_M, SECT_M_R
	} sector_t;

	localparam int PW = psca_pkg::PIX_W;
	localparam int CW = psca_pkg::C8_W;
	localparam int QW = psca_pkg::Q_W;
	localparam int PROD_W = CW + QW;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: distance to nearest even sector, offset m8
	logic [QW-1:0] f1, w1;

	always_comb begin
		f1 = hue[QW-1:0];
		w1 = f1[QW-1] ? QW'(14'd8192 - {1'b0, f1}) : f1;
	end

	logic [QW-1:0] w_s1;
	sector_t       sect_s1;
	logic [CW-1:0] c8_s1, m8_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			w_s1    <= w1;
			sect_s1 <= sector_t'(hue[psca_pkg::HUE_W-1:psca_pkg::HUE_FRAC]);
			c8_s1   <= chroma;
			m8_s1   <= {max_val, 8'd0} - chroma;
		end
	end

	// stage 2: intermediate component
	logic [PROD_W-1:0] prod2;

	assign prod2 = PROD_W'(c8_s1) * PROD_W'(w_s1);

	logic [CW-1:0] x8_s2, c8_s2, m8_s2;
	sector_t       sect_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			x8_s2   <= prod2[psca_pkg::HUE_FRAC +: CW];
			c8_s2   <= c8_s1;
			m8_s2   <= m8_s1;
			sect_s2 <= sect_s1;
		end
	end

	// stage 3: place components and add offset
	logic [CW-1:0] cr3, cg3, cb3;
	logic [CW:0]   sr3, sg3, sb3;

	always_comb begin
		case (sect_s2)
			SECT_R_Y: begin cr3 = c8_s2; cg3 = x8_s2; cb3 = '0;    end
			SECT_Y_G: begin cr3 = x8_s2; cg3 = c8_s2; cb3 = '0;    end
			SECT_G_C: begin cr3 = '0;    cg3 = c8_s2; cb3 = x8_s2; end
			SECT_C_B: begin cr3 = '0;    cg3 = x8_s2; cb3 = c8_s2; end
			SECT_B_M: begin cr3 = x8_s2; cg3 = '0;    cb3 = c8_s2; end
			default:  begin cr3 = c8_s2; cg3 = '0;    cb3 = x8_s2; end
		endcase
		sr3 = {1'b0, cr3} + {1'b0, m8_s2};
		sg3 = {1'b0, cg3} + {1'b0, m8_s2};
		sb3 = {1'b0, cb3} + {1'b0, m8_s2};
	end

	logic [PW-1:0] r_s3, g_s3, b_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			r_s3 <= sr3[CW-1:8];
			g_s3 <= sg3[CW-1:8];
			b_s3 <= sb3[CW-1:8];
		end
	end

	// stage 4: floor mean of the three by reciprocal multiply
	logic [9:0]  sum4;
	logic [19:0] avg_prod4;
	logic [PW-1:0] avg4;

	always_comb begin
		sum4 = 10'(r_s3) + 10'(g_s3) + 10'(b_s3);
		avg_prod4 = 20'(sum4) * 20'(psca_pkg::RECIP3);
		avg4 = avg_prod4[psca_pkg::RECIP3_SH +: PW];
	end

	logic [PW-1:0] r_s4, g_s4, b_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			r_s4 <= grayscale_enable ? avg4 : r_s3;
			g_s4 <= grayscale_enable ? avg4 : g_s3;
			b_s4 <= grayscale_enable ? avg4 : b_s3;
		end
	end

	assign out_valid = v_s4;
	assign red       = r_s4;
	assign green     = g_s4;
	assign blue      = b_s4;

endmodule

`default_nettype wire

FILE: rtl/psca_contrast.sv
// ----------------------------------------------------------------------------
// psca_contrast
// contrast about mid level with truncation and clamp, two register stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psca_contrast (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [psca_pkg::PIX_W-1:0]   red,
	input  wire logic [psca_pkg::PIX_W-1:0]   green,
	input  wire logic [psca_pkg::PIX_W-1:0]   blue,
	input  wire logic [psca_pkg::GAIN_W-1:0]  contrast_gain,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [psca_pkg::PIX_W-1:0]        red_out,
	output logic [psca_pkg::PIX_W-1:0]        green_out,
	output logic [psca_pkg::PIX_W-1:0]        blue_out
);

	localparam int PW = psca_pkg::PIX_W;
	localparam int P_W = PW + psca_pkg::GAIN_W + 2;

	logic v_s1, v_s2;
	logic en1, en2;

	assign en2 = !v_s2 || out_ready;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	// stage 1: signed product of distance from mid level and gain
	logic [PW-1:0]              ch1 [3];
	logic signed [PW:0]         d1  [3];
	logic signed [psca_pkg::GAIN_W:0] g1;
	logic signed [P_W-1:0]      p1  [3];

	always_comb begin
		ch1[0] = red;
		ch1[1] = green;
		ch1[2] = blue;
		g1 = $signed({1'b0, contrast_gain});
		for (int i = 0; i < 3; i++) begin
			d1[i] = $signed({1'b0, ch1[i]}) - $signed({1'b0, psca_pkg::MID_LEVEL});
			p1[i] = d1[i] * g1;
		end
	end

	logic signed [P_W-1:0] p_s1 [3];

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < 3; i++) p_s1[i] <= p1[i];
		end
	end

	// stage 2: divide by 256 toward zero, recenter, clamp
	logic signed [P_W-1:0]   t2 [3];
	logic signed [P_W-9:0]   q2 [3];
	logic signed [P_W-8:0]   r2 [3];
	logic [PW-1:0]           o2 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t2[i] = p_s1[i][P_W-1] ? p_s1[i] + P_W'(255) : p_s1[i];
			q2[i] = t2[i][P_W-1:8];
			r2[i] = {q2[i][P_W-9], q2[i]} + $signed({1'b0, psca_pkg::MID_LEVEL});
			if (r2[i][P_W-8]) o2[i] = '0;
			else if (r2[i] > $signed({1'b0, psca_pkg::TOP_LEVEL})) o2[i] = psca_pkg::TOP_LEVEL;
			else o2[i] = r2[i][PW-1:0];
		end
	end

	logic [PW-1:0] r_s2, g_s2, b_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			r_s2 <= o2[0];
			g_s2 <= o2[1];
			b_s2 <= o2[2];
		end
	end

	assign out_valid = v_s2;
	assign red_out   = r_s2;
	assign green_out = g_s2;
	assign blue_out  = b_s2;

endmodule

`default_nettype wire

FILE: rtl/pixel_saturation_contrast_adjust_unit.sv
// throughput: one word per cycle unless out_ready stalls the pipe; the hue
// divider is four stages of restoring steps so each stage starts a new pixel
// every cycle while the pipe is not stalled
// reset: arst_n clears all stage valid bits and sets grayscale off, both gains 256
// ----------------------------------------------------------------------------
// pixel_saturation_contrast_adjust_unit
// rgb -> hsv saturation gain -> rgb, optional gray mean, contrast about 128
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pixel_saturation_contrast_adjust_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration write port
	input  wire logic                               cfg_write_en,
	input  wire logic [psca_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [psca_pkg::GAIN_W-1:0]        cfg_data,
	// input pixel word
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [psca_pkg::PIX_W-1:0]         red_in,
	input  wire logic [psca_pkg::PIX_W-1:0]         green_in,
	input  wire logic [psca_pkg::PIX_W-1:0]         blue_in,
	// output pixel word
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [psca_pkg::PIX_W-1:0]              red_out,
	output logic [psca_pkg::PIX_W-1:0]              green_out,
	output logic [psca_pkg::PIX_W-1:0]              blue_out
);

	// configuration registers; the user must write them only while the pipe is empty, the block does not enforce it
	psca_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grayscale_enable <= 1'b0;
			cfg_q.contrast_gain    <= psca_pkg::GAIN_ONE;
			cfg_q.saturation_gain  <= psca_pkg::GAIN_ONE;
		end else if (cfg_write_en) begin
			case (psca_pkg::cfg_idx_t'(cfg_index))
				psca_pkg::CFG_GRAYSCALE:  cfg_q.grayscale_enable <= cfg_data[0];
				psca_pkg::CFG_CONTRAST:   cfg_q.contrast_gain    <= cfg_data;
				psca_pkg::CFG_SATURATION: cfg_q.saturation_gain  <= cfg_data;
				default: ; // unused index, write dropped
			endcase
		end
	end

	// hue section: max/min, 13-bit quotient over four stages, clamped chroma
	logic                            hue_valid, hue_ready;
	logic [psca_pkg::HUE_W-1:0]      hue;
	logic [psca_pkg::C8_W-1:0]       chroma;
	logic [psca_pkg::PIX_W-1:0]      max_val;

	psca_hue u_hue (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.red             (red_in),
		.green           (green_in),
		.blue            (blue_in),
		.saturation_gain (cfg_q.saturation_gain),
		.hue_valid       (hue_valid),
		.hue_ready       (hue_ready),
		.hue             (hue),
		.chroma          (chroma),
		.max_val         (max_val)
	);

	// back to rgb, then optional gray mean
	logic                        rgb_valid, rgb_ready;
	logic [psca_pkg::PIX_W-1:0]  rgb_r, rgb_g, rgb_b;

	psca_rgb u_rgb (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (hue_valid),
		.in_ready         (hue_ready),
		.hue              (hue),
		.chroma           (chroma),
		.max_val          (max_val),
		.grayscale_enable (cfg_q.grayscale_enable),
		.out_valid        (rgb_valid),
		.out_ready        (rgb_ready),
		.red              (rgb_r),
		.green            (rgb_g),
		.blue             (rgb_b)
	);

	// contrast, last stage is the output register
	psca_contrast u_contrast (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (rgb_valid),
		.in_ready      (rgb_ready),
		.red           (rgb_r),
		.green         (rgb_g),
		.blue          (rgb_b),
		.contrast_gain (cfg_q.contrast_gain),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.red_out       (red_out),
		.green_out     (green_out),
		.blue_out      (blue_out)
	);

endmodule

`default_nettype wire

FILE: rtl/psca_checker.sv
// ----------------------------------------------------------------------------
// psca_checker
// port level checks of the adjust unit, attached by bind
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psca_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [psca_pkg::PIX_W-1:0]  red_out,
	input wire logic [psca_pkg::PIX_W-1:0]  green_out,
	input wire logic [psca_pkg::PIX_W-1:0]  blue_out
);

	// a stalled output word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(red_out) && $stable(green_out)
			&& $stable(blue_out))
		else $error("output word changed while stalled");

	// an empty or draining output stage lets the whole pipe move
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled with free output stage");

	// no output word is valid directly out of reset
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !out_valid)
		else $error("output word right after reset");

endmodule

bind pixel_saturation_contrast_adjust_unit psca_checker u_psca_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.red_out   (red_out),
	.green_out (green_out),
	.blue_out  (blue_out)
);

`default_nettype wire
